[rtl/gauss_seidel_pagerank_sweep_unit_macros.svh]
// Assertion macros shared by the PageRank sweep unit files.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef GAUSS_SEIDEL_PAGERANK_SWEEP_UNIT_MACROS_SVH
`define GAUSS_SEIDEL_PAGERANK_SWEEP_UNIT_MACROS_SVH

// Same-cycle implication.
`define GSPRS_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication.
`define GSPRS_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/gsprs_pkg.sv]
// Package of the PageRank sweep unit: beat types, opcodes, register indexes,
// reset values and the clamped magnitude helper. No dependencies.
`timescale 1ns / 1ps

package gsprs_pkg;

  localparam int unsigned MAX_NODES_DEF = 1024;
  localparam int unsigned MAX_EDGES_DEF = 8192;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [3:0] {
    OP_RANK      = 4'd0,
    OP_COL_START = 4'd1,
    OP_ROW_INDEX = 4'd2,
    OP_EDGE_W    = 4'd3,
    OP_NODE_W    = 4'd4,
    OP_TELEPORT  = 4'd5,
    OP_SHARE     = 4'd6,
    OP_RUN       = 4'd7,
    OP_READ      = 4'd8
  } opcode_e;

  typedef enum logic [2:0] {
    CFG_NODE_COUNT       = 3'd0,
    CFG_DAMPING          = 3'd1,
    CFG_TELEPORT_GAIN    = 3'd2,
    CFG_USE_EDGE_WEIGHTS = 3'd3,
    CFG_TELEPORT_SCALAR  = 3'd4,
    CFG_SHARE_SCALAR     = 3'd5
  } cfg_index_e;

  localparam logic [10:0] NODE_COUNT_RST    = 11'd1;
  localparam logic [30:0] DAMPING_RST       = 31'd912680550;
  localparam logic [30:0] TELEPORT_GAIN_RST = 31'd161061274;

  localparam logic [63:0] LIM47     = 64'h0000_7FFF_FFFF_FFFF;
  localparam logic [63:0] LIM48M2   = 64'h0000_FFFF_FFFF_FFFE;
  localparam logic [63:0] COEF_LIM  = 64'h0000_0000_8000_0000;
  localparam logic signed [63:0] ONE_Q30 = 64'sh0000_0000_4000_0000;
  localparam logic signed [31:0] INT32_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] INT32_MIN = 32'sh8000_0000;

  typedef struct packed {
    logic [3:0]         opcode;
    logic [12:0]        index;
    logic signed [31:0] value;
    logic               sum_given;
  } item_t;

  typedef struct packed {
    logic               kind;
    logic signed [31:0] rank_value;
    logic [46:0]        change_sum;
    logic signed [47:0] dangling_sum;
  } result_t;

  function automatic logic [63:0] clamp_mag(input logic signed [63:0] v,
                                            input logic [63:0] lim);
    logic [63:0] m;
    m = v[63] ? (64'd0 - 64'(v)) : 64'(v);
    return (m > lim) ? lim : m;
  endfunction

endpackage

[rtl/gsprs_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
`timescale 1ns / 1ps

module gsprs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AddrW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

[rtl/gsprs_mul.sv]
// Shared Q30 multiplier: round(s * c / 2^30) with clamped operands, built
// from one 47 x 16 bit multiplier over two passes. Depends on gsprs_pkg.
`timescale 1ns / 1ps

module gsprs_mul (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start_i,
  input  logic signed [63:0] s_i,
  input  logic signed [32:0] c_i,
  output logic               done_o,
  output logic signed [63:0] prod_o
);
  import gsprs_pkg::*;

  typedef enum logic [1:0] {PH_IDLE, PH_LO, PH_HI, PH_SUM} phase_e;

  phase_e             phase_q;
  logic [46:0]        a_q;
  logic [31:0]        c_q;
  logic               neg_q;
  logic [62:0]        lo_q;
  logic [62:0]        hi_q;
  logic signed [63:0] prod_q;
  logic               done_q;
  logic [15:0]        c_half;
  logic [62:0]        m;
  logic [78:0]        sum;
  logic [48:0]        r;

  assign c_half = (phase_q == PH_LO) ? c_q[15:0] : c_q[31:16];
  assign m      = 63'(a_q) * 63'(c_half);
  assign sum    = {hi_q, 16'd0} + 79'(lo_q) + 79'(32'h2000_0000);
  assign r      = sum[78:30];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_IDLE;
      done_q  <= 1'b0;
      a_q     <= '0;
      c_q     <= '0;
      neg_q   <= 1'b0;
      lo_q    <= '0;
      hi_q    <= '0;
      prod_q  <= '0;
    end else begin
      done_q <= 1'b0;
      unique case (phase_q)
        PH_IDLE: begin
          if (start_i) begin
            a_q     <= 47'(clamp_mag(s_i, LIM47));
            c_q     <= 32'(clamp_mag(64'(c_i), COEF_LIM));
            neg_q   <= s_i[63] ^ c_i[32];
            phase_q <= PH_LO;
          end
        end
        PH_LO: begin
          lo_q    <= m;
          phase_q <= PH_HI;
        end
        PH_HI: begin
          hi_q    <= m;
          phase_q <= PH_SUM;
        end
        PH_SUM: begin
          prod_q  <= neg_q ? (64'sd0 - 64'(r)) : 64'(r);
          done_q  <= 1'b1;
          phase_q <= PH_IDLE;
        end
        default: phase_q <= PH_IDLE;
      endcase
    end
  end

  assign done_o = done_q;
  assign prod_o = prod_q;

endmodule

[rtl/gsprs_div.sv]
// Shared restoring divider, one quotient bit per cycle, used for the
// reciprocal of the node count, dangling corrections and the rank quotient.
`timescale 1ns / 1ps
`include "gauss_seidel_pagerank_sweep_unit_macros.svh"

module gsprs_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [49:0] rem_i,
  input  logic        quot_i,
  input  logic [31:0] dividend_i,
  input  logic [47:0] divisor_i,
  input  logic [5:0]  steps_i,
  output logic        done_o,
  output logic [32:0] quot_o
);

  logic        busy_q;
  logic        done_q;
  logic [5:0]  cnt_q;
  logic [49:0] rem_q;
  logic [32:0] quot_q;
  logic [31:0] dvd_q;
  logic [47:0] div_q;
  logic [49:0] rem_sh;
  logic        fits;

  assign rem_sh = {rem_q[48:0], dvd_q[31]};
  assign fits   = rem_sh >= {2'b00, div_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
      rem_q  <= '0;
      quot_q <= '0;
      dvd_q  <= '0;
      div_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= steps_i;
        rem_q  <= rem_i;
        quot_q <= {32'd0, quot_i};
        dvd_q  <= dividend_i;
        div_q  <= divisor_i;
      end else if (busy_q) begin
        if (cnt_q == 6'd0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end else begin
          rem_q  <= fits ? (rem_sh - {2'b00, div_q}) : rem_sh;
          quot_q <= {quot_q[31:0], fits};
          dvd_q  <= {dvd_q[30:0], 1'b0};
          cnt_q  <= cnt_q - 6'd1;
        end
      end
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

  `GSPRS_ASSERT_IMP(a_div_no_restart, start_i, !busy_q, "divider started while busy")

endmodule

[rtl/gauss_seidel_pagerank_sweep_unit.sv]
// Top level of the Gauss-Seidel PageRank sweep unit: sequencer, stores and
// configuration registers. Depends on gsprs_pkg, gsprs_ram, gsprs_mul, gsprs_div.
`timescale 1ns / 1ps
`include "gauss_seidel_pagerank_sweep_unit_macros.svh"

// Items arrive on item_i and are taken at a clock edge where start is high
// and busy is low. Load beats (rank, column start, row index, edge weight,
// node weight, teleport, share) are written in the accepting cycle and leave
// busy low, so loads stream at one beat per cycle.
// A read beat keeps busy high through S_READ and S_READ_OUT, and its result
// strobes on res_valid_o in the cycle after that.
// A run beat first sums the dangling ranks when no sum is given, then sweeps
// the nodes in order. Each node is sequenced on the shared multiplier and
// divider, with more work for a dangling node and for each ignored, self or
// other edge. One result beat then strobes for a single cycle; the receiver
// cannot stall it, and a new item may be started in that same cycle.
// Configuration beats are taken on the cfg channel whenever it is valid.
// Reset clears the sequencer and sets the configuration registers to their
// reset values; the stores hold nothing until loaded.

module gauss_seidel_pagerank_sweep_unit #(
  parameter int unsigned MAX_NODES = gsprs_pkg::MAX_NODES_DEF,
  parameter int unsigned MAX_EDGES = gsprs_pkg::MAX_EDGES_DEF
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 start,
  output logic                                 busy,
  input  gsprs_pkg::item_t                     item_i,
  output logic                                 res_valid_o,
  output gsprs_pkg::result_t                   res_o,
  input  logic                                 cfg_valid_i,
  output logic                                 cfg_ready_o,
  input  logic [gsprs_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [gsprs_pkg::CFG_DATA_W-1:0]     cfg_data_i
);
  import gsprs_pkg::*;

  localparam int unsigned NAW = $clog2(MAX_NODES);
  localparam int unsigned NCW = $clog2(MAX_NODES + 1);
  localparam int unsigned EAW = $clog2(MAX_EDGES);
  localparam int unsigned ECW = $clog2(MAX_EDGES + 1);

  typedef enum logic [4:0] {
    S_IDLE, S_READ, S_READ_OUT, S_DS_ADDR, S_DS_DATA, S_PREP, S_INVN_WAIT,
    S_NODE_A, S_NODE_B, S_NODE_C, S_EDGE_A, S_EDGE_B, S_EDGE_C, S_EDGE_MUL,
    S_SHARE_GO, S_SHARE_WAIT, S_DANG_GO, S_DANG_WAIT, S_NUM_GO, S_NUM_WAIT,
    S_TEL_GO, S_TEL_WAIT, S_DEN_GO, S_DEN_WAIT, S_DIV_GO, S_DIV_WAIT, S_WB,
    S_DONE
  } state_e;

  // Configuration registers.
  logic [10:0] node_count_q;
  logic [30:0] damping_q;
  logic [30:0] gain_q;
  logic        use_ew_q;
  logic        tel_scalar_q;
  logic        share_scalar_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_count_q   <= NODE_COUNT_RST;
      damping_q      <= DAMPING_RST;
      gain_q         <= TELEPORT_GAIN_RST;
      use_ew_q       <= 1'b0;
      tel_scalar_q   <= 1'b1;
      share_scalar_q <= 1'b1;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_NODE_COUNT:       node_count_q   <= cfg_data_i[10:0];
        CFG_DAMPING:          damping_q      <= cfg_data_i[30:0];
        CFG_TELEPORT_GAIN:    gain_q         <= cfg_data_i[30:0];
        CFG_USE_EDGE_WEIGHTS: use_ew_q       <= cfg_data_i[0];
        CFG_TELEPORT_SCALAR:  tel_scalar_q   <= cfg_data_i[0];
        CFG_SHARE_SCALAR:     share_scalar_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  assign cfg_ready_o = 1'b1;

  // Sequencer registers.
  state_e             state_q;
  item_t              item_q;
  logic [NCW-1:0]     n_q;
  logic [NCW-1:0]     i_q;
  logic [NCW-1:0]     j_q;
  logic [ECW-1:0]     k_q;
  logic [ECW-1:0]     en_q;
  logic               dang_q;
  logic signed [31:0] xo_q;
  logic signed [31:0] xn_q;
  logic signed [31:0] share_q;
  logic signed [31:0] vi_q;
  logic [31:0]        invn_q;
  logic signed [63:0] acc_q;
  logic signed [63:0] self_q;
  logic signed [63:0] dold_q;
  logic signed [63:0] dacc_q;
  logic signed [63:0] num_q;
  logic signed [63:0] den_q;
  logic [63:0]        diffs_q;
  logic               neg_q;
  result_t            res_q;
  logic               res_valid_q;

  // Store ports.
  logic           rank_we, cs_we, row_we, ew_we, nw_we, tp_we, sh_we;
  logic [NAW-1:0] rank_waddr, rank_raddr, nw_raddr, tp_raddr, sh_raddr;
  logic [31:0]    rank_wdata, rank_rdata, ew_rdata, nw_rdata, tp_rdata, sh_rdata;
  logic [NCW-1:0] cs_raddr, row_rdata, row_wdata, n_eff;
  logic [ECW-1:0] cs_rdata, cs_wdata;

  // Shared units.
  logic               mul_start, mul_done;
  logic signed [63:0] mul_s, mul_prod;
  logic signed [32:0] mul_c;
  logic               div_start, div_done;
  logic [49:0]        div_rem;
  logic               div_q0;
  logic [31:0]        div_dvd;
  logic [47:0]        div_dsr;
  logic [5:0]         div_steps;
  logic [32:0]        div_quot;

  logic               accept, node_idx_ok, cs_idx_ok, edge_idx_ok;
  logic signed [31:0] w;
  logic [31:0]        xo_mag;
  logic [47:0]        mn, md;
  logic               div_big, div_iq, div_neg, div_special;
  logic [32:0]        q_rnd;
  logic [31:0]        m_rnd;
  logic signed [32:0] dx;
  logic [32:0]        dx_mag;
  logic [31:0]        uv;

  assign busy   = (state_q != S_IDLE);
  assign accept = start && !busy;
  assign uv     = 32'(item_i.value);

  assign node_idx_ok = 32'(item_i.index) < 32'(MAX_NODES);
  assign cs_idx_ok   = 32'(item_i.index) <= 32'(MAX_NODES);
  assign edge_idx_ok = 32'(item_i.index) < 32'(MAX_EDGES);

  assign n_eff = (32'(node_count_q) > 32'(MAX_NODES)) ? NCW'(MAX_NODES) : NCW'(node_count_q);
  assign cs_wdata  = (uv > 32'(MAX_EDGES)) ? ECW'(MAX_EDGES) : ECW'(uv);
  assign row_wdata = (uv > 32'(MAX_NODES)) ? NCW'(MAX_NODES) : NCW'(uv);

  assign w      = use_ew_q ? $signed(ew_rdata) : $signed(nw_rdata);
  assign xo_mag = xo_q[31] ? (32'd0 - 32'(xo_q)) : 32'(xo_q);

  assign mn      = 48'(clamp_mag(num_q, LIM48M2));
  assign md      = 48'(clamp_mag(den_q, LIM48M2));
  assign div_big = {1'b0, mn} >= {md, 1'b0};
  assign div_iq  = mn >= md;
  assign div_neg = num_q[63] ^ den_q[63];
  assign div_special = (num_q == 64'sd0) || (den_q == 64'sd0) || div_big;

  assign q_rnd = 33'(div_quot[31:0]) + 33'd1;
  assign m_rnd = q_rnd[32:1];

  assign dx     = 33'(xo_q) - 33'(xn_q);
  assign dx_mag = dx[32] ? 33'(-dx) : 33'(dx);

  // Store addressing and writes.
  always_comb begin
    rank_we    = 1'b0;
    rank_waddr = NAW'(item_i.index);
    rank_wdata = 32'(item_i.value);
    rank_raddr = i_q[NAW-1:0];
    nw_raddr   = i_q[NAW-1:0];
    cs_raddr   = (state_q == S_NODE_B) ? NCW'(i_q + NCW'(1)) : i_q;
    tp_raddr   = tel_scalar_q ? '0 : i_q[NAW-1:0];
    sh_raddr   = share_scalar_q ? '0 : i_q[NAW-1:0];
    cs_we = accept && (item_i.opcode == OP_COL_START) && cs_idx_ok;
    row_we = accept && (item_i.opcode == OP_ROW_INDEX) && edge_idx_ok;
    ew_we = accept && (item_i.opcode == OP_EDGE_W) && edge_idx_ok;
    nw_we = accept && (item_i.opcode == OP_NODE_W) && node_idx_ok;
    tp_we = accept && (item_i.opcode == OP_TELEPORT) && node_idx_ok;
    sh_we = accept && (item_i.opcode == OP_SHARE) && node_idx_ok;
    unique case (state_q)
      S_IDLE: rank_we = accept && (item_i.opcode == OP_RANK) && node_idx_ok;
      S_READ: rank_raddr = NAW'(item_q.index);
      S_EDGE_B: begin
        rank_raddr = row_rdata[NAW-1:0];
        nw_raddr   = row_rdata[NAW-1:0];
      end
      S_WB: begin
        rank_we    = 1'b1;
        rank_waddr = i_q[NAW-1:0];
        rank_wdata = 32'(xn_q);
      end
      default: ;
    endcase
  end

  // Operand selection for the shared units.
  always_comb begin
    mul_start = 1'b0;
    mul_s     = 64'(xo_q);
    mul_c     = $signed({2'b00, damping_q});
    div_start = 1'b0;
    div_rem   = '0;
    div_q0    = 1'b0;
    div_dvd   = xo_mag + 32'(n_q >> 1);
    div_dsr   = 48'(n_q);
    div_steps = 6'd32;
    unique case (state_q)
      S_EDGE_C: begin
        mul_start = (j_q != i_q);
        mul_s     = 64'($signed(rank_rdata));
        mul_c     = 33'(w);
      end
      S_SHARE_GO: begin
        mul_start = 1'b1;
        mul_s     = dold_q + dacc_q;
        mul_c     = 33'(share_q);
      end
      S_NUM_GO: begin
        mul_start = 1'b1;
        mul_s     = acc_q;
      end
      S_TEL_GO: begin
        mul_start = 1'b1;
        mul_s     = 64'(vi_q);
        mul_c     = $signed({2'b00, gain_q});
      end
      S_DEN_GO: begin
        mul_start = 1'b1;
        mul_s     = self_q;
      end
      S_PREP: begin
        div_start = (n_q != '0);
        div_dvd   = 32'h4000_0000 + 32'(n_q >> 1);
      end
      S_DANG_GO: div_start = dang_q;
      S_DIV_GO: begin
        div_start = !div_special;
        div_rem   = div_iq ? 50'(mn - md) : 50'(mn);
        div_q0    = div_iq;
        div_dvd   = '0;
        div_dsr   = md;
        div_steps = 6'd31;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      item_q      <= '0;
      n_q         <= '0;
      i_q         <= '0;
      j_q         <= '0;
      k_q         <= '0;
      en_q        <= '0;
      dang_q      <= 1'b0;
      xo_q        <= '0;
      xn_q        <= '0;
      share_q     <= '0;
      vi_q        <= '0;
      invn_q      <= '0;
      acc_q       <= '0;
      self_q      <= '0;
      dold_q      <= '0;
      dacc_q      <= '0;
      num_q       <= '0;
      den_q       <= '0;
      diffs_q     <= '0;
      neg_q       <= 1'b0;
      res_q       <= '0;
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start) begin
            item_q <= item_i;
            unique case (item_i.opcode)
              OP_RUN: begin
                n_q     <= n_eff;
                i_q     <= '0;
                dacc_q  <= '0;
                diffs_q <= '0;
                if (item_i.sum_given) begin
                  dold_q  <= 64'(item_i.value);
                  state_q <= S_PREP;
                end else begin
                  dold_q  <= '0;
                  state_q <= S_DS_ADDR;
                end
              end
              OP_READ: state_q <= S_READ;
              default: ;
            endcase
          end
        end
        S_READ: state_q <= S_READ_OUT;
        S_READ_OUT: begin
          res_q.kind         <= 1'b0;
          res_q.rank_value   <= (32'(item_q.index) < 32'(MAX_NODES)) ?
                                $signed(rank_rdata) : 32'sd0;
          res_q.change_sum   <= '0;
          res_q.dangling_sum <= '0;
          res_valid_q        <= 1'b1;
          state_q            <= S_IDLE;
        end
        S_DS_ADDR: state_q <= (i_q == n_q) ? S_PREP : S_DS_DATA;
        S_DS_DATA: begin
          if (nw_rdata == 32'd0) begin
            dold_q <= dold_q + 64'($signed(rank_rdata));
          end
          i_q     <= NCW'(i_q + NCW'(1));
          state_q <= S_DS_ADDR;
        end
        S_PREP: begin
          i_q     <= '0;
          state_q <= (n_q == '0) ? S_DONE : S_INVN_WAIT;
        end
        S_INVN_WAIT: begin
          if (div_done) begin
            invn_q  <= div_quot[31:0];
            state_q <= S_NODE_A;
          end
        end
        S_NODE_A: begin
          acc_q   <= '0;
          self_q  <= '0;
          state_q <= (i_q == n_q) ? S_DONE : S_NODE_B;
        end
        S_NODE_B: begin
          k_q     <= cs_rdata;
          dang_q  <= (nw_rdata == 32'd0);
          xo_q    <= $signed(rank_rdata);
          share_q <= $signed(sh_rdata);
          vi_q    <= $signed(tp_rdata);
          state_q <= S_NODE_C;
        end
        S_NODE_C: begin
          en_q    <= cs_rdata;
          state_q <= S_EDGE_A;
        end
        S_EDGE_A: state_q <= (k_q >= en_q) ? S_SHARE_GO : S_EDGE_B;
        S_EDGE_B: begin
          j_q <= row_rdata;
          if (row_rdata >= n_q) begin
            k_q     <= ECW'(k_q + ECW'(1));
            state_q <= S_EDGE_A;
          end else begin
            state_q <= S_EDGE_C;
          end
        end
        S_EDGE_C: begin
          if (j_q == i_q) begin
            self_q  <= self_q + 64'(w);
            k_q     <= ECW'(k_q + ECW'(1));
            state_q <= S_EDGE_A;
          end else begin
            state_q <= S_EDGE_MUL;
          end
        end
        S_EDGE_MUL: begin
          if (mul_done) begin
            acc_q   <= acc_q + mul_prod;
            k_q     <= ECW'(k_q + ECW'(1));
            state_q <= S_EDGE_A;
          end
        end
        S_SHARE_GO: state_q <= S_SHARE_WAIT;
        S_SHARE_WAIT: begin
          if (mul_done) begin
            acc_q   <= acc_q + mul_prod;
            state_q <= S_DANG_GO;
          end
        end
        S_DANG_GO: state_q <= dang_q ? S_DANG_WAIT : S_NUM_GO;
        S_DANG_WAIT: begin
          if (div_done) begin
            acc_q   <= xo_q[31] ? (acc_q + 64'(div_quot[31:0]))
                                : (acc_q - 64'(div_quot[31:0]));
            self_q  <= self_q + 64'(invn_q);
            state_q <= S_NUM_GO;
          end
        end
        S_NUM_GO: state_q <= S_NUM_WAIT;
        S_NUM_WAIT: begin
          if (mul_done) begin
            num_q   <= mul_prod;
            state_q <= S_TEL_GO;
          end
        end
        S_TEL_GO: state_q <= S_TEL_WAIT;
        S_TEL_WAIT: begin
          if (mul_done) begin
            num_q   <= num_q + mul_prod;
            state_q <= S_DEN_GO;
          end
        end
        S_DEN_GO: state_q <= S_DEN_WAIT;
        S_DEN_WAIT: begin
          if (mul_done) begin
            den_q   <= ONE_Q30 - mul_prod;
            state_q <= S_DIV_GO;
          end
        end
        S_DIV_GO: begin
          if (num_q == 64'sd0) begin
            xn_q    <= 32'sd0;
            state_q <= S_WB;
          end else if (den_q == 64'sd0) begin
            xn_q    <= num_q[63] ? INT32_MIN : INT32_MAX;
            state_q <= S_WB;
          end else if (div_big) begin
            xn_q    <= div_neg ? INT32_MIN : INT32_MAX;
            state_q <= S_WB;
          end else begin
            neg_q   <= div_neg;
            state_q <= S_DIV_WAIT;
          end
        end
        S_DIV_WAIT: begin
          if (div_done) begin
            if (neg_q) begin
              xn_q <= $signed(32'd0 - m_rnd);
            end else begin
              xn_q <= m_rnd[31] ? INT32_MAX : $signed(m_rnd);
            end
            state_q <= S_WB;
          end
        end
        S_WB: begin
          if (dang_q) begin
            dold_q <= dold_q - 64'(xo_q);
            dacc_q <= dacc_q + 64'(xn_q);
          end
          diffs_q <= diffs_q + 64'(dx_mag);
          i_q     <= NCW'(i_q + NCW'(1));
          state_q <= S_NODE_A;
        end
        S_DONE: begin
          res_q.kind       <= 1'b1;
          res_q.rank_value <= '0;
          res_q.change_sum <= (diffs_q > LIM47) ? 47'(LIM47) : diffs_q[46:0];
          if (dacc_q > $signed(LIM47)) begin
            res_q.dangling_sum <= 48'sh7FFF_FFFF_FFFF;
          end else if (dacc_q < -$signed(LIM47) - 64'sd1) begin
            res_q.dangling_sum <= 48'sh8000_0000_0000;
          end else begin
            res_q.dangling_sum <= dacc_q[47:0];
          end
          res_valid_q <= 1'b1;
          state_q     <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  gsprs_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_rank (
    .clk_i, .we_i(rank_we), .waddr_i(rank_waddr), .wdata_i(rank_wdata),
    .raddr_i(rank_raddr), .rdata_o(rank_rdata)
  );

  gsprs_ram #(.WIDTH(ECW), .DEPTH(MAX_NODES + 1)) u_col_start (
    .clk_i, .we_i(cs_we), .waddr_i(NCW'(item_i.index)), .wdata_i(cs_wdata),
    .raddr_i(cs_raddr), .rdata_o(cs_rdata)
  );

  gsprs_ram #(.WIDTH(NCW), .DEPTH(MAX_EDGES)) u_row_index (
    .clk_i, .we_i(row_we), .waddr_i(EAW'(item_i.index)), .wdata_i(row_wdata),
    .raddr_i(k_q[EAW-1:0]), .rdata_o(row_rdata)
  );

  gsprs_ram #(.WIDTH(32), .DEPTH(MAX_EDGES)) u_edge_weight (
    .clk_i, .we_i(ew_we), .waddr_i(EAW'(item_i.index)), .wdata_i(uv),
    .raddr_i(k_q[EAW-1:0]), .rdata_o(ew_rdata)
  );

  gsprs_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_node_weight (
    .clk_i, .we_i(nw_we), .waddr_i(NAW'(item_i.index)), .wdata_i(uv),
    .raddr_i(nw_raddr), .rdata_o(nw_rdata)
  );

  gsprs_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_teleport (
    .clk_i, .we_i(tp_we), .waddr_i(NAW'(item_i.index)), .wdata_i(uv),
    .raddr_i(tp_raddr), .rdata_o(tp_rdata)
  );

  gsprs_ram #(.WIDTH(32), .DEPTH(MAX_NODES)) u_share (
    .clk_i, .we_i(sh_we), .waddr_i(NAW'(item_i.index)), .wdata_i(uv),
    .raddr_i(sh_raddr), .rdata_o(sh_rdata)
  );

  gsprs_mul u_mul (
    .clk_i, .rst_ni, .start_i(mul_start), .s_i(mul_s), .c_i(mul_c),
    .done_o(mul_done), .prod_o(mul_prod)
  );

  gsprs_div u_div (
    .clk_i, .rst_ni, .start_i(div_start), .rem_i(div_rem), .quot_i(div_q0),
    .dividend_i(div_dvd), .divisor_i(div_dsr), .steps_i(div_steps),
    .done_o(div_done), .quot_o(div_quot)
  );

  `GSPRS_ASSERT_NXT(a_strobe_single, res_valid_q, !res_valid_q, "result beat held over two cycles")
  `GSPRS_ASSERT_IMP(a_strobe_idle, res_valid_q, state_q == S_IDLE, "result beat while sequencer busy")
  `GSPRS_ASSERT_IMP(a_wb_in_range, state_q == S_WB, i_q < n_q, "rank write-back beyond node count")
  `GSPRS_ASSERT_IMP(a_mul_done_wait, mul_done, state_q == S_EDGE_MUL || state_q == S_SHARE_WAIT || state_q == S_NUM_WAIT || state_q == S_TEL_WAIT || state_q == S_DEN_WAIT, "product arrived outside a wait state")

endmodule
